// ===== design/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the divide-by-count table of the 3x3 RGB box blur.
package bb3_pkg;

  localparam int DEFAULT_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT        = 4096;

  localparam int WIDTH_W  = 12;   // frame_width register
  localparam int HEIGHT_W = 13;   // frame_height register
  localparam int CFG_W    = 13;   // configuration data, widest register
  localparam int CNT_W    = 13;   // position and pending counters
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int SUM_W    = 12;   // nine 8-bit values
  localparam int NUM_W    = 13;   // 2*sum + count
  localparam int CNT9_W   = 4;    // neighbour count, 1..9
  localparam int RECIP_W  = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W   = NUM_W + RECIP_W;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

  // Register indexes of the configuration port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Item codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XREAD,
    ST_SHIFT,
    ST_SUM,
    ST_DIV
  } state_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // Edge masks of the result position, captured when the item is accepted
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } res_mask_t;

  // ceil(2^RECIP_SHIFT / (2*n)); exact floor division for numerators below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT9_W-1:0] n);
    logic [RECIP_W-1:0] r;
    begin
      unique case (n)
        4'd1:    r = 18'd131072;
        4'd2:    r = 18'd65536;
        4'd3:    r = 18'd43691;
        4'd4:    r = 18'd32768;
        4'd5:    r = 18'd26215;
        4'd6:    r = 18'd21846;
        4'd7:    r = 18'd18725;
        4'd8:    r = 18'd16384;
        4'd9:    r = 18'd14564;
        default: r = 18'd131072;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== design/box_blur_3x3_rgb_top.sv =====
`timescale 1ns / 1ps
// Flow: an accepted item passes SHIFT; one giving a result then passes SUM and DIV, and
// DIV waits to load the output register while it is full and stalled. One item at a
// time; an ignored drain stays in IDLE; the last pixel of a one-row frame adds a fill
// step through XREAD. The rate is set by the sequencer around the line stores.
// Reset: counters clear, size returns to 640x480; line stores keep their contents
// (entries outside the frame are masked, so no clearing pass is run).
module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH = bb3_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [bb3_pkg::CHAN_W-1:0]    red_in,
  input  logic [bb3_pkg::CHAN_W-1:0]    green_in,
  input  logic [bb3_pkg::CHAN_W-1:0]    blue_in,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bb3_pkg::CHAN_W-1:0]    red_out,
  output logic [bb3_pkg::CHAN_W-1:0]    green_out,
  output logic [bb3_pkg::CHAN_W-1:0]    blue_out,
  output logic                          frame_end
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W  = bb3_pkg::CNT_W;
  localparam int CHAN_W = bb3_pkg::CHAN_W;

  // Configuration registers and effective frame size
  logic [bb3_pkg::WIDTH_W-1:0]  width_reg;
  logic [bb3_pkg::HEIGHT_W-1:0] height_reg;
  logic [CNT_W-1:0]             eff_w;
  logic [CNT_W-1:0]             eff_h;

  // Frame position state
  bb3_pkg::state_t state, state_next;
  logic [CNT_W-1:0] in_col, in_col_next;     // column of the next window column
  logic [CNT_W-1:0] pix_row, pix_row_next;   // row of the next real pixel
  logic [CNT_W-1:0] pending, pending_next;   // pixels received but not answered
  logic [CNT_W-1:0] res_row, res_row_next;
  logic [CNT_W-1:0] res_col, res_col_next;
  logic             all_in, all_in_next;
  logic             extra, extra_next;       // one fill step owed (one-row frame)

  // Per-item registers
  logic                 emit;
  bb3_pkg::res_mask_t   mask;
  bb3_pkg::pixel_t      px_reg;
  logic [ADDR_W-1:0]    wr_addr;

  // Line stores
  bb3_pkg::pixel_t upper_mem  [MAX_WIDTH];
  bb3_pkg::pixel_t middle_mem [MAX_WIDTH];
  bb3_pkg::pixel_t upper_rd;
  bb3_pkg::pixel_t middle_rd;
  logic            mem_rd;
  logic            mem_wr;
  logic [ADDR_W-1:0] rd_addr;

  // 3x3 window: [row][col], row 0 on top, col 2 newest
  bb3_pkg::pixel_t win [3][3];

  // Sum and divide
  logic [bb3_pkg::NUM_W-1:0]   num_r, num_g, num_b;
  logic [bb3_pkg::NUM_W-1:0]   num_r_next, num_g_next, num_b_next;
  logic [bb3_pkg::RECIP_W-1:0] recip_q, recip_next;
  logic [bb3_pkg::PROD_W-1:0]  prod_r, prod_g, prod_b;
  logic                        out_load;

  // Handshake decode
  logic in_fire;
  logic is_real;
  logic do_shift;
  logic col_wrap;
  logic emit_now;
  logic is_last;

  // -------------------------------------------------------------------------
  // Effective size: zero counts as one, saturate to the storage limits
  // -------------------------------------------------------------------------
  always_comb begin
    if (width_reg == '0) begin
      eff_w = CNT_W'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = CNT_W'(width_reg);
    end
    if (height_reg == '0) begin
      eff_h = CNT_W'(1);
    end else if (32'(height_reg) > bb3_pkg::MAX_HEIGHT) begin
      eff_h = CNT_W'(bb3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = CNT_W'(height_reg);
    end
  end

  // -------------------------------------------------------------------------
  // Item decode. A pixel before the frame is complete enters the window; once
  // every pixel is in, any beat acts as a drain and shifts a virtual column
  // so the window keeps moving toward the results still owed.
  // -------------------------------------------------------------------------
  assign in_fire  = in_valid && !in_stall;
  assign is_real  = (op == bb3_pkg::OP_PIXEL) && !all_in;
  assign do_shift = is_real || all_in;
  assign col_wrap = ({1'b0, in_col} + 1'b1) >= {1'b0, eff_w};
  assign emit_now = all_in || (is_real && ({1'b0, pending} >= ({1'b0, eff_w} + 1'b1)));
  assign is_last  = (res_row == eff_h - 1'b1) && (res_col == eff_w - 1'b1);

  always_comb begin
    in_col_next  = in_col;
    pix_row_next = pix_row;
    pending_next = pending;
    res_row_next = res_row;
    res_col_next = res_col;
    all_in_next  = all_in;
    extra_next   = extra;

    if (state == bb3_pkg::ST_IDLE && in_fire && do_shift) begin
      in_col_next = col_wrap ? '0 : in_col + 1'b1;
      if (is_real) begin
        if (col_wrap) begin
          pix_row_next = pix_row + 1'b1;
          if (({1'b0, pix_row} + 1'b1) >= {1'b0, eff_h}) begin
            all_in_next = 1'b1;
            // a one-row frame is one column short of its first result
            extra_next  = (eff_h == CNT_W'(1));
          end
        end
        if (!emit_now) begin
          pending_next = pending + 1'b1;
        end
      end else begin
        pending_next = pending - 1'b1;
      end
      if (emit_now) begin
        if (({1'b0, res_col} + 1'b1) >= {1'b0, eff_w}) begin
          res_col_next = '0;
          res_row_next = res_row + 1'b1;
        end else begin
          res_col_next = res_col + 1'b1;
        end
        if (is_last) begin
          // frame done: start over with the next pixel
          in_col_next  = '0;
          pix_row_next = '0;
          pending_next = '0;
          res_row_next = '0;
          res_col_next = '0;
          all_in_next  = 1'b0;
          extra_next   = 1'b0;
        end
      end
    end else if (state == bb3_pkg::ST_XREAD) begin
      in_col_next = col_wrap ? '0 : in_col + 1'b1;
      extra_next  = 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      bb3_pkg::ST_IDLE: begin
        if (in_fire && do_shift) begin
          state_next = bb3_pkg::ST_SHIFT;
        end
      end
      bb3_pkg::ST_XREAD: begin
        state_next = bb3_pkg::ST_SHIFT;
      end
      bb3_pkg::ST_SHIFT: begin
        if (emit) begin
          state_next = bb3_pkg::ST_SUM;
        end else if (extra) begin
          state_next = bb3_pkg::ST_XREAD;
        end else begin
          state_next = bb3_pkg::ST_IDLE;
        end
      end
      bb3_pkg::ST_SUM: begin
        state_next = bb3_pkg::ST_DIV;
      end
      bb3_pkg::ST_DIV: begin
        if (out_load) begin
          state_next = bb3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bb3_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    mem_rd   = 1'b0;
    mem_wr   = 1'b0;
    out_load = 1'b0;
    rd_addr  = in_col[ADDR_W-1:0];
    unique case (state)
      bb3_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        mem_rd   = in_valid && do_shift;
      end
      bb3_pkg::ST_XREAD: begin
        mem_rd = 1'b1;
      end
      bb3_pkg::ST_SHIFT: begin
        mem_wr = 1'b1;
      end
      bb3_pkg::ST_SUM: begin
        out_load = 1'b0;
      end
      bb3_pkg::ST_DIV: begin
        // load when the output register is empty or being drained this cycle
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bb3_pkg::ST_IDLE;
      width_reg  <= bb3_pkg::RESET_WIDTH;
      height_reg <= bb3_pkg::RESET_HEIGHT;
      in_col     <= '0;
      pix_row    <= '0;
      pending    <= '0;
      res_row    <= '0;
      res_col    <= '0;
      all_in     <= 1'b0;
      extra      <= 1'b0;
      emit       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        // a register write restarts the frame and drops owed results
        unique case (cfg_index)
          bb3_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data[bb3_pkg::WIDTH_W-1:0];
          bb3_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data[bb3_pkg::HEIGHT_W-1:0];
          default: width_reg <= width_reg;
        endcase
        in_col  <= '0;
        pix_row <= '0;
        pending <= '0;
        res_row <= '0;
        res_col <= '0;
        all_in  <= 1'b0;
        extra   <= 1'b0;
      end else begin
        in_col  <= in_col_next;
        pix_row <= pix_row_next;
        pending <= pending_next;
        res_row <= res_row_next;
        res_col <= res_col_next;
        all_in  <= all_in_next;
        extra   <= extra_next;
      end
      if (state == bb3_pkg::ST_IDLE && in_fire) begin
        emit <= do_shift && emit_now;
      end else if (state == bb3_pkg::ST_XREAD) begin
        emit <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-item payload: pixel, write address, edge masks of the result
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      wr_addr <= rd_addr;
    end
    if (state == bb3_pkg::ST_IDLE && in_fire) begin
      px_reg      <= {red_in, green_in, blue_in};
      mask.top    <= (res_row == '0);
      mask.bottom <= (res_row == eff_h - 1'b1);
      mask.left   <= (res_col == '0);
      mask.right  <= (res_col == eff_w - 1'b1);
      mask.last   <= is_last;
    end
  end

  // -------------------------------------------------------------------------
  // Line stores: read at accept, write back in the following SHIFT state. One item is in
  // flight at a time, so a write always lands before the next read.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      upper_mem[wr_addr]  <= middle_rd;
      middle_mem[wr_addr] <= px_reg;
    end
    if (mem_rd) begin
      upper_rd  <= upper_mem[rd_addr];
      middle_rd <= middle_mem[rd_addr];
    end
  end

  // Window: advance one column per shift
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= upper_rd;
      win[1][2] <= middle_rd;
      win[2][2] <= px_reg;
    end
  end

  // -------------------------------------------------------------------------
  // Sum the in-frame neighbours; the numerator 2*sum + n rounds halves up
  // -------------------------------------------------------------------------
  always_comb begin
    logic [2:0]                 row_on;
    logic [2:0]                 col_on;
    logic [1:0]                 rows;
    logic [1:0]                 cols;
    logic [CNT9_W_L-1:0]        n;
    logic [bb3_pkg::SUM_W-1:0]  sr, sg, sb;
    row_on = {!mask.bottom, 1'b1, !mask.top};
    col_on = {!mask.right, 1'b1, !mask.left};
    rows   = 2'(row_on[0]) + 2'(row_on[1]) + 2'(row_on[2]);
    cols   = 2'(col_on[0]) + 2'(col_on[1]) + 2'(col_on[2]);
    n      = CNT9_W_L'(rows) * CNT9_W_L'(cols);
    sr = '0;
    sg = '0;
    sb = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_on[r] && col_on[c]) begin
          sr = sr + bb3_pkg::SUM_W'(win[r][c][3*CHAN_W-1:2*CHAN_W]);
          sg = sg + bb3_pkg::SUM_W'(win[r][c][2*CHAN_W-1:CHAN_W]);
          sb = sb + bb3_pkg::SUM_W'(win[r][c][CHAN_W-1:0]);
        end
      end
    end
    num_r_next = {sr, 1'b0} + bb3_pkg::NUM_W'(n);
    num_g_next = {sg, 1'b0} + bb3_pkg::NUM_W'(n);
    num_b_next = {sb, 1'b0} + bb3_pkg::NUM_W'(n);
    recip_next = bb3_pkg::recip(n);
  end

  localparam int CNT9_W_L = bb3_pkg::CNT9_W;

  always_ff @(posedge clk) begin
    if (state == bb3_pkg::ST_SUM) begin
      num_r   <= num_r_next;
      num_g   <= num_g_next;
      num_b   <= num_b_next;
      recip_q <= recip_next;
    end
  end

  // Divide by 2n through the reciprocal; one multiplier per channel
  assign prod_r = bb3_pkg::PROD_W'(num_r) * bb3_pkg::PROD_W'(recip_q);
  assign prod_g = bb3_pkg::PROD_W'(num_g) * bb3_pkg::PROD_W'(recip_q);
  assign prod_b = bb3_pkg::PROD_W'(num_b) * bb3_pkg::PROD_W'(recip_q);

  // Output register: holds the beat until the far side takes it
  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out   <= prod_r[bb3_pkg::RECIP_SHIFT +: CHAN_W];
      green_out <= prod_g[bb3_pkg::RECIP_SHIFT +: CHAN_W];
      blue_out  <= prod_b[bb3_pkg::RECIP_SHIFT +: CHAN_W];
      frame_end <= mask.last;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 RGB box blur: directed cases and frames of random pixels scored against a model.
module tb_top;
  import bb3_pkg::*;

  // Depth of the row history kept by the model; four rows keep the
  // three rows of a window apart from the row being written.
  localparam int HIST_DEPTH = 4;
  localparam int PLAN_LEN = 33;
  localparam int RANDOM_BEATS = 450;

  // One blurred output pixel as it leaves the block
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic last;
  } blur_px_t;

  // One row of the directed plan: a register write or an input beat,
  // with a hand-typed result where it is plain to see
  typedef struct packed {
    logic is_reg;
    logic reg_idx;
    logic [CFG_W-1:0] reg_val;
    logic op_i;
    pixel_t px;
    logic typed;
    blur_px_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic op;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic out_valid;
  logic out_stall;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic frame_end;

  // Hand-typed expectation that travels with the beat it belongs to
  logic chk_typed;
  blur_px_t chk_px;

  // Blur model state
  pixel_t hist_rows [HIST_DEPTH][DEFAULT_MAX_WIDTH];
  logic [WIDTH_W-1:0] width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [CNT_W-1:0] next_row;
  logic [CNT_W-1:0] next_col;
  logic [CNT_W-1:0] owed;
  logic [CNT_W-1:0] out_row;
  logic [CNT_W-1:0] out_col;
  logic frame_in;

  blur_px_t blurred_q [$];
  int unsigned mismatches = 0;
  bit calm = 1'b0;
  plan_row_t plan [PLAN_LEN];

  box_blur_3x3_rgb_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .frame_end(frame_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Blur model
  // ---------------------------------------------------------------------------

  // Frame size in use: zero counts as one, oversize clamps to the store limits.
  function automatic logic [CNT_W-1:0] span_cols();
    logic [CNT_W-1:0] w;
    w = {1'b0, width_reg};
    if (w == 0) w = 1;
    if (w > DEFAULT_MAX_WIDTH) w = DEFAULT_MAX_WIDTH;
    return w;
  endfunction

  function automatic logic [CNT_W-1:0] span_rows();
    logic [CNT_W-1:0] h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  task automatic frame_restart();
    next_row = '0;
    next_col = '0;
    owed = '0;
    out_row = '0;
    out_col = '0;
    frame_in = 1'b0;
  endtask

  // Average the in-frame part of the window around the next output position,
  // rounding halves up, then advance that position.
  task automatic window_average(input logic [CNT_W-1:0] w, input logic [CNT_W-1:0] h,
                                output blur_px_t res);
    int unsigned sr, sg, sb, n;
    int rr, cc, dr, dc;
    pixel_t p;
    sr = 0;
    sg = 0;
    sb = 0;
    n = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        rr = int'(out_row) + dr;
        cc = int'(out_col) + dc;
        if (rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w)) begin
          p = hist_rows[rr & (HIST_DEPTH - 1)][cc];
          sr += p[23:16];
          sg += p[15:8];
          sb += p[7:0];
          n++;
        end
      end
    end
    res.red = CHAN_W'((2 * sr + n) / (2 * n));
    res.green = CHAN_W'((2 * sg + n) / (2 * n));
    res.blue = CHAN_W'((2 * sb + n) / (2 * n));
    res.last = (out_row == h - 1) && (out_col == w - 1);
    out_col++;
    if (out_col >= w) begin
      out_col = '0;
      out_row++;
    end
    if (res.last) frame_restart();
  endtask

  // Take one accepted beat; report whether it releases a blurred pixel.
  task automatic blur_step(input logic op_i, input pixel_t px, output bit got,
                           output blur_px_t res);
    logic [CNT_W-1:0] w, h;
    w = span_cols();
    h = span_rows();
    got = 1'b0;
    res = '0;
    if (op_i == OP_PIXEL && !frame_in) begin
      hist_rows[next_row[1:0]][next_col] = px;
      next_col++;
      if (next_col >= w) begin
        next_col = '0;
        next_row++;
        if (next_row >= h) frame_in = 1'b1;
      end
      owed++;
      // Output trails the input by one row plus one pixel
      if (owed > w + 1) begin
        owed--;
        window_average(w, h, res);
        got = 1'b1;
      end
    end else if (frame_in && owed > 0) begin
      // Drain, or a pixel arriving after the last one of the frame
      owed--;
      window_average(w, h, res);
      got = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoring
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int unsigned seen,
                               input int unsigned wanted);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, seen, wanted);
  endtask

  // Score the output beat first, then fold register writes and input beats
  // into the model; everything is sampled at the edge, before new drives land.
  always @(posedge clk) begin : scoreboard
    bit got;
    blur_px_t res;
    blur_px_t want;
    if (rst) begin
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      frame_restart();
      blurred_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          flag_mismatch("output beat with nothing expected", red_out, 0);
        end else begin
          want = blurred_q.pop_front();
          if (red_out !== want.red) flag_mismatch("red_out", red_out, want.red);
          if (green_out !== want.green) flag_mismatch("green_out", green_out, want.green);
          if (blue_out !== want.blue) flag_mismatch("blue_out", blue_out, want.blue);
          if (frame_end !== want.last) flag_mismatch("frame_end", frame_end, want.last);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data[WIDTH_W-1:0];
        else height_reg = cfg_data[HEIGHT_W-1:0];
        // Any write starts the frame over and drops owed pixels
        frame_restart();
      end
      if (in_valid && !in_stall) begin
        blur_step(op, {red_in, green_in, blue_in}, got, res);
        if (chk_typed) blurred_q.push_back(chk_px);
        else if (got) blurred_q.push_back(res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Traffic shaping
  // ---------------------------------------------------------------------------

  // Gap length: mostly none, some short, a few long; none during calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Alternate busy stretches with calm ones where neither side idles.
  initial begin
    forever begin
      calm = 1'b0;
      repeat ($urandom_range(150, 500)) @(negedge clk);
      calm = 1'b1;
      repeat ($urandom_range(40, 120)) @(negedge clk);
    end
  end

  // Output back-pressure, independent of out_valid so stalls hit every phase
  initial begin : sink_stall
    int unsigned stall_len;
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Favor the channel extremes
  function automatic logic [CHAN_W-1:0] chan_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  function automatic pixel_t any_pixel();
    return {chan_level(), chan_level(), chan_level()};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Drive one input beat, hold it until accepted. On return valid is still
  // high; the caller's next drive at this same step replaces or drops it.
  task automatic push_beat(input logic op_i, input pixel_t px, input logic typed,
                           input blur_px_t typed_px);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_i;
    red_in <= px[23:16];
    green_in <= px[15:8];
    blue_in <= px[7:0];
    chk_typed <= typed;
    chk_px <= typed_px;
    do @(posedge clk); while (in_stall);
  endtask

  // Write a register once the block has gone quiet
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    // Let the last accepted beat reach the scoreboard before looking at the queue
    @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    // Cover work still in flight for beats that release nothing
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic plan_row_t reg_row(input logic idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic plan_row_t beat_row(input logic op_i, input pixel_t px);
    plan_row_t row;
    row = '0;
    row.op_i = op_i;
    row.px = px;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic op_i, input pixel_t px,
                                          input blur_px_t want);
    plan_row_t row;
    row = beat_row(op_i, px);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [CFG_W-1:0] wv, hv;
    int unsigned beats, phase, sel, n_frames, w_eff, h_eff, total, n_pix, n_drain, f, k;
    bit tall, broken;

    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= OP_PIXEL;
    red_in <= '0;
    green_in <= '0;
    blue_in <= '0;
    chk_typed <= 1'b0;
    chk_px <= '0;

    plan = '{
      // Drain straight after reset: frame not complete, dropped
      beat_row(OP_DRAIN, 24'h123456),
      // Zero sizes act as a 1x1 frame: the pixel comes back as is
      reg_row(REG_FRAME_WIDTH, 13'd0),
      reg_row(REG_FRAME_HEIGHT, 13'd0),
      beat_row(OP_PIXEL, 24'hFF0080),
      typed_row(OP_DRAIN, 24'h000000, {8'hFF, 8'h00, 8'h80, 1'b1}),
      // Nothing owed: dropped
      beat_row(OP_DRAIN, 24'hFFFFFF),
      // 2x1 frame of black and white: both outputs round 127.5 up
      reg_row(REG_FRAME_WIDTH, 13'd2),
      reg_row(REG_FRAME_HEIGHT, 13'd1),
      beat_row(OP_PIXEL, 24'h000000),
      beat_row(OP_PIXEL, 24'hFFFFFF),
      typed_row(OP_DRAIN, 24'hA5A5A5, {8'h80, 8'h80, 8'h80, 1'b0}),
      // Pixel past the end of the frame drains the last output
      typed_row(OP_PIXEL, 24'h00FF00, {8'h80, 8'h80, 8'h80, 1'b1}),
      // Next frame starts with no register write
      beat_row(OP_PIXEL, 24'h00FF00),
      beat_row(OP_PIXEL, 24'h0000FF),
      beat_row(OP_DRAIN, 24'h000000),
      beat_row(OP_DRAIN, 24'h5A5A5A),
      // 3x2 checkerboard of channel extremes
      reg_row(REG_FRAME_WIDTH, 13'd3),
      reg_row(REG_FRAME_HEIGHT, 13'd2),
      beat_row(OP_PIXEL, 24'hFF00FF),
      beat_row(OP_PIXEL, 24'h00FF00),
      beat_row(OP_PIXEL, 24'hFF00FF),
      beat_row(OP_PIXEL, 24'h00FF00),
      beat_row(OP_PIXEL, 24'hFF00FF),
      beat_row(OP_PIXEL, 24'h00FF00),
      beat_row(OP_DRAIN, 24'hFFFFFF),
      beat_row(OP_DRAIN, 24'h000000),
      beat_row(OP_DRAIN, 24'hFFFFFF),
      beat_row(OP_DRAIN, 24'h000000),
      // All-ones sizes clamp to the store limits; rewrite mid-frame drops it
      reg_row(REG_FRAME_WIDTH, 13'h0FFF),
      reg_row(REG_FRAME_HEIGHT, 13'h1FFF),
      beat_row(OP_PIXEL, 24'h800001),
      beat_row(OP_PIXEL, 24'h7FFFFE),
      reg_row(REG_FRAME_WIDTH, 13'd1)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else push_beat(plan[i].op_i, plan[i].px, plan[i].typed, plan[i].want);
    end

    // Random frames: mostly small and complete, some cut short by a register
    // write, a few very tall, and one pass across the full line store width.
    beats = 0;
    phase = 0;
    while (beats < RANDOM_BEATS) begin
      phase++;
      tall = 1'b0;
      broken = 1'b0;
      n_pix = 0;
      n_frames = 1;
      sel = $urandom_range(0, 99);
      if (phase == 3) begin
        // Widest row, cut short a few outputs into the frame
        wv = DEFAULT_MAX_WIDTH;
        hv = 13'd2;
        tall = 1'b1;
        n_pix = DEFAULT_MAX_WIDTH + 8;
      end else if (sel < 6) begin
        // Tall frame that never completes
        wv = $urandom_range(1, 3);
        case ($urandom_range(0, 2))
          0: hv = MAX_HEIGHT;
          1: hv = '1;
          default: hv = $urandom_range(64, 8191);
        endcase
        tall = 1'b1;
        n_pix = $urandom_range(8, 40);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 5) wv = 0;
        else if (sel < 15) wv = 1;
        else if (sel < 90) wv = $urandom_range(2, 8);
        else wv = $urandom_range(9, 40);
        sel = $urandom_range(0, 99);
        if (sel < 5) hv = 0;
        else if (sel < 20) hv = 1;
        else hv = $urandom_range(2, 6);
        n_frames = $urandom_range(1, 2);
        broken = ($urandom_range(0, 99) < 15);
      end
      write_reg(REG_FRAME_WIDTH, wv);
      write_reg(REG_FRAME_HEIGHT, hv);
      w_eff = (wv == 0) ? 1 : wv;
      h_eff = (hv == 0) ? 1 : hv;

      for (f = 0; f < n_frames; f++) begin
        total = w_eff * h_eff;
        if (!tall) begin
          n_pix = total;
          if (broken && f == n_frames - 1) n_pix = $urandom_range(0, total - 1);
        end
        for (k = 0; k < n_pix; k++) begin
          // Stray drain before the frame is in: dropped, not counted
          if ($urandom_range(0, 99) < 4) push_beat(OP_DRAIN, any_pixel(), 1'b0, '0);
          push_beat(OP_PIXEL, any_pixel(), 1'b0, '0);
          if (phase != 3) beats++;
        end
        if (n_pix == total) begin
          // Owed outputs: one row plus one pixel, or the whole frame if smaller
          n_drain = (total < w_eff + 1) ? total : w_eff + 1;
          for (k = 0; k < n_drain; k++) begin
            push_beat(($urandom_range(0, 99) < 20) ? OP_PIXEL : OP_DRAIN, any_pixel(),
                      1'b0, '0);
            beats++;
          end
          // Drain with nothing owed: dropped
          if ($urandom_range(0, 99) < 20) push_beat(OP_DRAIN, any_pixel(), 1'b0, '0);
        end
      end
    end

    // Wind down: collect what is owed, then watch for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("box_blur_3x3_rgb_top test passed");
    end else begin
      $display("box_blur_3x3_rgb_top test failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("box_blur_3x3_rgb_top test failed");
    $finish;
  end

endmodule
